>>> rtl/smds_pkg.sv
// Shared types, constants and decode functions for the data stack block.
// No dependencies; imported by smds_ctrl, smds_dpath and the top level.

package smds_pkg;

   // Default number of stack entries
   localparam int unsigned DEFAULT_STACK_DEPTH = 64;

   localparam int unsigned WORD_WIDTH  = 32;
   localparam int unsigned CMD_WIDTH   = 4;
   localparam int unsigned DEPTH_WIDTH = 7;
   localparam int unsigned ERR_WIDTH   = 2;

   // Command codes
   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_PUSH   = 4'd0,
      CMD_ADD    = 4'd1,
      CMD_SUB    = 4'd2,
      CMD_MUL    = 4'd3,
      CMD_POPOUT = 4'd4,
      CMD_DROP   = 4'd5,
      CMD_DUP    = 4'd6,
      CMD_SWAP   = 4'd7,
      CMD_NIP    = 4'd8,
      CMD_OVER   = 4'd9,
      CMD_TUCK   = 4'd10,
      CMD_LT     = 4'd11,
      CMD_GT     = 4'd12,
      CMD_EQ     = 4'd13
   } cmd_type;

   // Error codes
   typedef enum logic [ERR_WIDTH-1:0] {
      ERR_NONE  = 2'd0,
      ERR_UNDER = 2'd1,
      ERR_OVER  = 2'd2
   } err_type;

   // Step strobes from controller to datapath
   typedef struct packed {
      logic load;    // latch the incoming word
      logic fetch;   // read third entry from memory
      logic exec;    // apply the command
   } dp_cmd_type;

   localparam logic [WORD_WIDTH-1:0] TRUE_FLAG = '1;

   // Entries a command needs on the stack
   function automatic logic [1:0] need_count(input logic [CMD_WIDTH-1:0] cmd);
      logic [1:0] n;
      case (cmd) inside
         CMD_PUSH:                     n = 2'd0;
         CMD_POPOUT, CMD_DROP, CMD_DUP: n = 2'd1;
         [CMD_ADD:CMD_MUL], [CMD_SWAP:CMD_EQ]: n = 2'd2;
         default:                      n = 2'd0;
      endcase
      return n;
   endfunction

   // Commands that add one entry net
   function automatic logic grows(input logic [CMD_WIDTH-1:0] cmd);
      logic g;
      case (cmd) inside
         CMD_PUSH, CMD_DUP, CMD_OVER, CMD_TUCK: g = 1'b1;
         default:                               g = 1'b0;
      endcase
      return g;
   endfunction

endpackage

>>> rtl/smds_ctrl.sv
// Sequencer for the data stack: accept, fetch, execute, reply.
// Depends on smds_pkg for the step strobe struct.

module smds_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_valid,
   output smds_pkg::dp_cmd_type  dp_cmd
);
   import smds_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_EXEC  = 4'b0100,
      ST_REPLY = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   // A word may be taken while idle or while the previous reply is out
   assign busy   = (state_ff == ST_FETCH) || (state_ff == ST_EXEC);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_FETCH;
         ST_FETCH: state_in = ST_EXEC;
         ST_EXEC:  state_in = ST_REPLY;
         ST_REPLY: state_in = accept ? ST_FETCH : ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Strobes to the datapath
   assign dp_cmd.load  = accept;
   assign dp_cmd.fetch = (state_ff == ST_FETCH);
   assign dp_cmd.exec  = (state_ff == ST_EXEC);
   assign rsp_valid    = (state_ff == ST_REPLY);

endmodule

>>> rtl/smds_dpath.sv
// Datapath: top two entries in registers, the rest in a memory, plus the ALU.
// Depends on smds_pkg for command codes, error codes and decode functions.

module smds_dpath #(
   parameter int unsigned STACK_DEPTH = smds_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  smds_pkg::dp_cmd_type                  dp_cmd,
   input  logic [smds_pkg::CMD_WIDTH-1:0]        req_command,
   input  logic signed [smds_pkg::WORD_WIDTH-1:0] req_literal,
   output logic signed [smds_pkg::WORD_WIDTH-1:0] rsp_top_value,
   output logic [smds_pkg::DEPTH_WIDTH-1:0]      rsp_stack_depth,
   output logic signed [smds_pkg::WORD_WIDTH-1:0] rsp_popped_value,
   output logic                                  rsp_popped_valid,
   output logic [smds_pkg::ERR_WIDTH-1:0]        rsp_error_code
);
   import smds_pkg::*;

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

   // Entries below the top two; index equals stack position
   logic [WORD_WIDTH-1:0] mem [STACK_DEPTH];

   logic [CMD_WIDTH-1:0]  cmd_ff;
   logic [WORD_WIDTH-1:0] lit_ff;
   logic [WORD_WIDTH-1:0] rd_ff;
   logic [WORD_WIDTH-1:0] tos_ff, tos_in;
   logic [WORD_WIDTH-1:0] nos_ff, nos_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [WORD_WIDTH-1:0] popped_ff, popped_in;
   logic                  pvalid_ff, pvalid_in;
   err_type               err_ff, err_in;

   logic                  wr_en;
   logic [WORD_WIDTH-1:0] wr_data;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic                  underflow, overflow, two_held;

   assign wr_addr  = AW'(count_ff - CW'(2));
   assign rd_addr  = AW'(count_ff - CW'(3));
   assign two_held = (count_ff >= CW'(2));

   // Error checks, underflow first
   assign underflow = (count_ff < CW'(need_count(cmd_ff)));
   assign overflow  = grows(cmd_ff) && (count_ff >= CW'(STACK_DEPTH));

   // Latch the incoming word
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         cmd_ff <= req_command;
         lit_ff <= req_literal;
      end
   end

   // Memory: registered read of the third entry, write on execute
   always_ff @(posedge clock) begin
      if (dp_cmd.fetch) begin
         rd_ff <= mem[rd_addr];
      end
      if (dp_cmd.exec && wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Command execution; b is tos, a is nos, rd_ff refills nos on a pop
   always_comb begin
      tos_in    = tos_ff;
      nos_in    = nos_ff;
      count_in  = count_ff;
      popped_in = '0;
      pvalid_in = 1'b0;
      err_in    = ERR_NONE;
      wr_en     = 1'b0;
      wr_data   = nos_ff;
      if (underflow) begin
         err_in = ERR_UNDER;
      end else if (overflow) begin
         err_in = ERR_OVER;
      end else begin
         case (cmd_ff)
            CMD_PUSH: begin
               wr_en    = two_held;
               nos_in   = tos_ff;
               tos_in   = lit_ff;
               count_in = count_ff + CW'(1);
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_NIP, CMD_LT, CMD_GT, CMD_EQ: begin
               nos_in   = rd_ff;
               count_in = count_ff - CW'(1);
               case (cmd_ff)
                  CMD_ADD: tos_in = nos_ff + tos_ff;
                  CMD_SUB: tos_in = nos_ff - tos_ff;
                  CMD_MUL: tos_in = nos_ff * tos_ff;
                  CMD_LT:  tos_in = ($signed(nos_ff) < $signed(tos_ff)) ? TRUE_FLAG : '0;
                  CMD_GT:  tos_in = ($signed(nos_ff) > $signed(tos_ff)) ? TRUE_FLAG : '0;
                  CMD_EQ:  tos_in = (nos_ff == tos_ff) ? TRUE_FLAG : '0;
                  default: tos_in = tos_ff;   // nip keeps the top
               endcase
            end
            CMD_POPOUT, CMD_DROP: begin
               popped_in = (cmd_ff == CMD_POPOUT) ? tos_ff : '0;
               pvalid_in = (cmd_ff == CMD_POPOUT);
               tos_in    = nos_ff;
               nos_in    = rd_ff;
               count_in  = count_ff - CW'(1);
            end
            CMD_DUP: begin
               wr_en    = two_held;
               nos_in   = tos_ff;
               count_in = count_ff + CW'(1);
            end
            CMD_SWAP: begin
               tos_in = nos_ff;
               nos_in = tos_ff;
            end
            CMD_OVER: begin
               wr_en    = 1'b1;
               nos_in   = tos_ff;
               tos_in   = nos_ff;
               count_in = count_ff + CW'(1);
            end
            CMD_TUCK: begin
               // a b -> b a b: old top goes to memory, registers keep a b
               wr_en    = 1'b1;
               wr_data  = tos_ff;
               count_in = count_ff + CW'(1);
            end
            default: begin
            end
         endcase
      end
   end

   // Stack pointer is control state; the rest is payload
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (dp_cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.exec) begin
         tos_ff    <= tos_in;
         nos_ff    <= nos_in;
         popped_ff <= popped_in;
         pvalid_ff <= pvalid_in;
         err_ff    <= err_in;
      end
   end

   // Result word
   assign rsp_top_value    = (count_ff == '0) ? '0 : tos_ff;
   assign rsp_stack_depth  = DEPTH_WIDTH'(count_ff);
   assign rsp_popped_value = popped_ff;
   assign rsp_popped_valid = pvalid_ff;
   assign rsp_error_code   = err_ff;

endmodule

>>> rtl/stack_machine_data_stack.sv
// Stack machine data stack with ALU: top level joining controller and datapath.
// Depends on smds_pkg, smds_ctrl and smds_dpath.

// One command word is taken at a clock edge where start is high and busy is
// low. After the fetch and execute states, its result word is driven on the
// rsp_ ports in the reply state, marked by rsp_valid for exactly that cycle,
// and must be taken at the edge that ends it: there is no backpressure. A new
// word can be issued in the cycle the previous result is shown, but not while
// busy in fetch or execute. The three steps are latch, registered read of the
// third stack entry from the entry memory, and execute; the top two entries
// live in registers. Underflow and overflow report an error code and leave the
// stack as it was. No clearing pass is needed after reset.

module stack_machine_data_stack #(
   parameter int unsigned STACK_DEPTH = smds_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [smds_pkg::CMD_WIDTH-1:0]         req_command,
   input  logic signed [smds_pkg::WORD_WIDTH-1:0] req_literal,
   output logic                                   rsp_valid,
   output logic signed [smds_pkg::WORD_WIDTH-1:0] rsp_top_value,
   output logic [smds_pkg::DEPTH_WIDTH-1:0]       rsp_stack_depth,
   output logic signed [smds_pkg::WORD_WIDTH-1:0] rsp_popped_value,
   output logic                                   rsp_popped_valid,
   output logic [smds_pkg::ERR_WIDTH-1:0]         rsp_error_code
);
   import smds_pkg::*;

   dp_cmd_type dp_cmd;

   smds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .dp_cmd    (dp_cmd)
   );

   smds_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .req_command      (req_command),
      .req_literal      (req_literal),
      .rsp_top_value    (rsp_top_value),
      .rsp_stack_depth  (rsp_stack_depth),
      .rsp_popped_value (rsp_popped_value),
      .rsp_popped_valid (rsp_popped_valid),
      .rsp_error_code   (rsp_error_code)
   );

endmodule
